### sv/rc4sc_pkg.sv
// ----------------------------------------------------------------------------
// rc4sc_pkg
// Shared widths, register indexes and reset values of the RC4 stream cipher.
// ----------------------------------------------------------------------------
package rc4sc_pkg;

	localparam int DATA_W      = 8;
	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int KEY_REG_W   = 64;
	localparam int KEY_LEN_W   = 5;
	localparam int KEY_POS_W   = 4;
	localparam int CFG_IDX_W   = 2;

	// largest key the design supports, in bytes
	localparam int KEY_BYTES_MAX_DEF = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_LOW    = 2'd0,
		CFG_KEY_HIGH   = 2'd1,
		CFG_KEY_LENGTH = 2'd2
	} cfg_idx_t;

	// default key is the five bytes "CD&ML"
	localparam logic [KEY_REG_W-1:0] KEY_LOW_RST    = 64'h0000_004C_4D26_4443;
	localparam logic [KEY_REG_W-1:0] KEY_HIGH_RST   = '0;
	localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RST = 5'd5;

	typedef logic [DATA_W-1:0] byte_t;
	typedef logic [ADDR_W-1:0] addr_t;

endpackage

### sv/rc4sc_ram.sv
// ----------------------------------------------------------------------------
// rc4sc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rc4sc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold the last read word while no read is issued
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 keystream engine with one persistent context and one table RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction  Notes
//  --------  ----------------------------------------  ---------  ---------------------
//  in        in_valid/in_ready, operation, data_in,    sink       rekey or data byte
//            last_byte
//  out       out_valid/out_ready, data_out,            source     one per data byte
//            last_byte_out
//  cfg       cfg_we, cfg_index, cfg_wdata              sink       write only, no wait
//
// Once keyed, a data byte runs: read S[i], read S[j], write S[i] while reading the
// keystream entry, write S[j]. The single table RAM (one read, one write port)
// forces this order. Data before the first rekey goes through the pass state.
// A rekey first fills the identity permutation, then makes four RAM accesses
// per schedule step. Reset clears indices, the keyed flag and the handshake;
// the table is not cleared. A stalled output holds the engine in its last
// step; the next transaction is taken once idle.
//
module rc4_stream_cipher #(
	parameter int KEY_BYTES_MAX = rc4sc_pkg::KEY_BYTES_MAX_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 operation,
	input  logic [rc4sc_pkg::DATA_W-1:0]         data_in,
	input  logic                                 last_byte,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [rc4sc_pkg::DATA_W-1:0]         data_out,
	output logic                                 last_byte_out,
	input  logic                                 cfg_we,
	input  logic [rc4sc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rc4sc_pkg::KEY_REG_W-1:0]      cfg_wdata
);
	import rc4sc_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_FILL   = 10'b00_0000_0010,
		ST_K_RD_I = 10'b00_0000_0100,
		ST_K_RD_J = 10'b00_0000_1000,
		ST_K_WR_I = 10'b00_0001_0000,
		ST_K_WR_J = 10'b00_0010_0000,
		ST_D_RD_J = 10'b00_0100_0000,
		ST_D_WR_I = 10'b00_1000_0000,
		ST_D_WR_J = 10'b01_0000_0000,
		ST_PASS   = 10'b10_0000_0000
	} state_t;

	// where the keystream byte comes from once the swap has landed
	typedef enum logic [1:0] {
		KS_MEM = 2'd0,
		KS_SI  = 2'd1,
		KS_SJ  = 2'd2
	} ks_src_t;

	localparam logic [KEY_LEN_W-1:0] LEN_MAX = KEY_LEN_W'(KEY_BYTES_MAX);
	localparam addr_t                LAST_N  = addr_t'(TABLE_DEPTH - 1);

	state_t state_q, state_d;

	// configuration registers
	logic [KEY_REG_W-1:0] key_low_q, key_high_q;
	logic [KEY_LEN_W-1:0] key_length_q;

	// cipher context
	addr_t  i_q, j_q;
	logic   keyed_q;

	// working registers
	addr_t                n_q;
	addr_t                ip_q, jp_q;
	byte_t                si_q, sj_q;
	logic [KEY_POS_W-1:0] kpos_q;
	logic [KEY_LEN_W-1:0] eff_len_q;
	ks_src_t              ks_src_q;
	byte_t                data_q;
	logic                 last_q;

	// output register
	logic  out_valid_q;
	byte_t out_data_q;
	logic  out_last_q;

	// RAM ports
	logic  ram_we, ram_re;
	addr_t ram_waddr, ram_raddr;
	byte_t ram_wdata, ram_rdata;

	logic                   in_fire, out_free, out_load;
	byte_t                  out_data_d;
	byte_t                  key_byte;
	logic [2*KEY_REG_W-1:0] key_all;
	logic [KEY_LEN_W-1:0]   kpos_inc;
	logic [KEY_LEN_W-1:0]   eff_len_d;
	addr_t                  i_next, j_data, j_key, ks_addr;
	byte_t                  keystream;

	rc4sc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// key byte selection; byte 0 sits in the low bits of key_low
	assign key_all  = {key_high_q, key_low_q};
	assign key_byte = key_all[kpos_q*DATA_W +: DATA_W];
	assign kpos_inc = KEY_LEN_W'(kpos_q) + KEY_LEN_W'(1);

	// clamp the key length to 1..KEY_BYTES_MAX when a rekey starts
	always_comb begin
		eff_len_d = key_length_q;
		if (key_length_q == '0) begin
			eff_len_d = KEY_LEN_W'(1);
		end else if (key_length_q > LEN_MAX) begin
			eff_len_d = LEN_MAX;
		end
	end

	assign i_next  = i_q + addr_t'(1);
	assign j_data  = j_q + ram_rdata;
	assign j_key   = j_q + ram_rdata + key_byte;
	assign ks_addr = si_q + ram_rdata;

	// forward the swapped values when the keystream entry is i or j itself
	always_comb begin
		case (ks_src_q)
			KS_SI:   keystream = si_q;
			KS_SJ:   keystream = sj_q;
			default: keystream = ram_rdata;
		endcase
	end

	// sequencer and RAM port control
	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_waddr  = n_q;
		ram_wdata  = ram_rdata;
		ram_re     = 1'b0;
		ram_raddr  = n_q;
		out_load   = 1'b0;
		out_data_d = data_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (operation) begin
						state_d = ST_FILL;
					end else if (keyed_q) begin
						ram_re    = 1'b1;
						ram_raddr = i_next;
						state_d   = ST_D_RD_J;
					end else begin
						state_d = ST_PASS;
					end
				end
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = n_q;
				ram_wdata = n_q;
				if (n_q == LAST_N) begin
					state_d = ST_K_RD_I;
				end
			end
			ST_K_RD_I: begin
				ram_re    = 1'b1;
				ram_raddr = n_q;
				state_d   = ST_K_RD_J;
			end
			ST_K_RD_J: begin
				ram_re    = 1'b1;
				ram_raddr = j_key;
				state_d   = ST_K_WR_I;
			end
			ST_K_WR_I: begin
				ram_we    = 1'b1;
				ram_waddr = n_q;
				ram_wdata = ram_rdata;
				state_d   = ST_K_WR_J;
			end
			ST_K_WR_J: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = si_q;
				state_d   = (n_q == LAST_N) ? ST_IDLE : ST_K_RD_I;
			end
			ST_D_RD_J: begin
				ram_re    = 1'b1;
				ram_raddr = j_data;
				state_d   = ST_D_WR_I;
			end
			ST_D_WR_I: begin
				ram_we    = 1'b1;
				ram_waddr = ip_q;
				ram_wdata = ram_rdata;
				ram_re    = 1'b1;
				ram_raddr = ks_addr;
				state_d   = ST_D_WR_J;
			end
			ST_D_WR_J: begin
				// repeat the write while the output stalls; it is idempotent
				ram_we     = 1'b1;
				ram_waddr  = jp_q;
				ram_wdata  = si_q;
				out_data_d = data_q ^ keystream;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_PASS: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			key_low_q    <= KEY_LOW_RST;
			key_high_q   <= KEY_HIGH_RST;
			key_length_q <= KEY_LENGTH_RST;
			i_q          <= '0;
			j_q          <= '0;
			keyed_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_KEY_LOW:    key_low_q    <= cfg_wdata;
					CFG_KEY_HIGH:   key_high_q   <= cfg_wdata;
					CFG_KEY_LENGTH: key_length_q <= cfg_wdata[KEY_LEN_W-1:0];
					default:        ;
				endcase
			end

			case (state_q)
				ST_FILL: begin
					j_q <= '0;
				end
				ST_K_RD_J: begin
					j_q <= j_key;
				end
				ST_K_WR_J: begin
					if (n_q == LAST_N) begin
						i_q     <= '0;
						j_q     <= '0;
						keyed_q <= 1'b1;
					end
				end
				ST_D_WR_J: begin
					if (out_free) begin
						i_q <= ip_q;
						j_q <= jp_q;
					end
				end
				default: ;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working and payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_q    <= data_in;
			last_q    <= last_byte;
			eff_len_q <= eff_len_d;
			n_q       <= '0;
			ip_q      <= i_next;
		end

		case (state_q)
			ST_FILL: begin
				n_q    <= n_q + addr_t'(1);
				kpos_q <= '0;
			end
			ST_K_RD_J: begin
				si_q <= ram_rdata;
			end
			ST_K_WR_J: begin
				n_q    <= n_q + addr_t'(1);
				kpos_q <= (kpos_inc >= eff_len_q) ? '0 : kpos_inc[KEY_POS_W-1:0];
			end
			ST_D_RD_J: begin
				si_q <= ram_rdata;
				jp_q <= j_data;
			end
			ST_D_WR_I: begin
				sj_q <= ram_rdata;
				if (ks_addr == jp_q) begin
					ks_src_q <= KS_SI;
				end else if (ks_addr == ip_q) begin
					ks_src_q <= KS_SJ;
				end else begin
					ks_src_q <= KS_MEM;
				end
			end
			default: ;
		endcase

		if (out_load) begin
			out_data_q <= out_data_d;
			out_last_q <= last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign data_out      = out_data_q;
	assign last_byte_out = out_last_q;

endmodule

### tb/sv/rc4_stream_cipher_tb.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_tb
// Self-checking testbench for the RC4 keystream engine. A directed table
// covers pass-through before the first key schedule, byte extremes, key
// length clamping, the unused register index and key extremes. Random
// phases follow: reprogram the key, run the schedule, stream data. Every
// result is checked against an in-bench cipher model, or a pass-through value.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import rc4sc_pkg::*;

	localparam int KEY_BYTES_MAX = KEY_BYTES_MAX_DEF;

	// operation codes of an input transaction
	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_REKEY = 1'b1;

	// register index past the end of the map; writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

	localparam int RESET_CYCLES = 6;
	// length of the key schedule; SETTLE gives it some slack
	localparam int REKEY_CYCLES = 1281;
	localparam int SETTLE       = REKEY_CYCLES + 64;
	localparam int RANDOM_ITEMS = 500;
	localparam int QUIET_ITEMS  = 60;
	localparam int LONG_HOLD    = 200;
	localparam int CYCLE_LIMIT  = 1_000_000;

	typedef struct packed {
		byte_t data;
		logic  last;
	} cipher_out_t;

	typedef enum logic [0:0] {
		ROW_ITEM,
		ROW_REG
	} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic                   op;
		byte_t                  data;
		logic                   last;
		bit                     typed;
		cipher_out_t            want;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [KEY_REG_W-1:0]   reg_val;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  operation;
	byte_t                 data_in;
	logic                  last_byte;
	logic                  out_valid;
	logic                  out_ready;
	byte_t                 data_out;
	logic                  last_byte_out;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [KEY_REG_W-1:0]  cfg_wdata;

	// cipher model state
	logic [KEY_REG_W-1:0]  key_lo_m;
	logic [KEY_REG_W-1:0]  key_hi_m;
	logic [KEY_LEN_W-1:0]  key_len_m;
	byte_t                 sbox [TABLE_DEPTH];
	addr_t                 ks_i;
	addr_t                 ks_j;
	bit                    keyed_m;

	cipher_out_t           expected_bytes [$];
	stim_row_t             stim_rows [$];

	int                    errors = 0;
	int                    cycle_count = 0;
	bit                    quiet = 1'b0;
	bit                    last_was_rekey = 1'b0;
	int                    hold_requests = 0;
	int                    hold_served = 0;
	int                    tx_calm = 0;

	rc4_stream_cipher i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.data_in       (data_in),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.data_out      (data_out),
		.last_byte_out (last_byte_out),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Cipher model
	// ------------------------------------------------------------------

	// zero counts as one byte, anything past the table limit saturates
	function automatic int unsigned key_len_used();
		int unsigned n;
		n = key_len_m;
		if (n == 0)
			n = 1;
		if (n > KEY_BYTES_MAX)
			n = KEY_BYTES_MAX;
		return n;
	endfunction

	function automatic byte_t key_byte_at(int unsigned k);
		if (k < 8)
			return key_lo_m[8*k +: 8];
		return key_hi_m[8*(k-8) +: 8];
	endfunction

	task automatic run_key_schedule();
		addr_t       j;
		int unsigned kpos;
		int unsigned len;
		byte_t       t;
		j = '0;
		kpos = 0;
		len = key_len_used();
		for (int n = 0; n < TABLE_DEPTH; n++)
			sbox[n] = byte_t'(n);
		for (int n = 0; n < TABLE_DEPTH; n++) begin
			j = j + sbox[n] + key_byte_at(kpos);
			t = sbox[n];
			sbox[n] = sbox[j];
			sbox[j] = t;
			kpos++;
			if (kpos >= len)
				kpos = 0;
		end
		ks_i = '0;
		ks_j = '0;
		keyed_m = 1'b1;
	endtask

	function automatic byte_t keystream_byte();
		byte_t t;
		ks_i = ks_i + 1'b1;
		ks_j = ks_j + sbox[ks_i];
		t = sbox[ks_i];
		sbox[ks_i] = sbox[ks_j];
		sbox[ks_j] = t;
		return sbox[addr_t'(sbox[ks_i] + sbox[ks_j])];
	endfunction

	// advance the model by one transaction; a rekey yields no byte
	task automatic cipher_step(input logic op, input byte_t data, input logic last,
			output bit produces, output cipher_out_t res);
		produces = 1'b0;
		res = '0;
		if (op == OP_REKEY) begin
			run_key_schedule();
		end else begin
			res.data = keyed_m ? (data ^ keystream_byte()) : data;
			res.last = last;
			produces = 1'b1;
		end
	endtask

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_REG_W-1:0] val);
		case (idx)
			CFG_KEY_LOW:    key_lo_m = val;
			CFG_KEY_HIGH:   key_hi_m = val;
			CFG_KEY_LENGTH: key_len_m = val[KEY_LEN_W-1:0];
			default:        ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Stimulus table
	// ------------------------------------------------------------------

	task automatic add_item(input logic op, input byte_t data, input logic last);
		stim_row_t r;
		r = '{kind: ROW_ITEM, op: op, data: data, last: last, typed: 1'b0,
			want: '0, reg_idx: '0, reg_val: '0};
		stim_rows = {stim_rows, r};
	endtask

	// unkeyed data must come back untouched, so the result is known up front
	task automatic add_passthru(input byte_t data, input logic last);
		stim_row_t r;
		r = '{kind: ROW_ITEM, op: OP_DATA, data: data, last: last, typed: 1'b1,
			want: '{data: data, last: last}, reg_idx: '0, reg_val: '0};
		stim_rows = {stim_rows, r};
	endtask

	task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_REG_W-1:0] val);
		stim_row_t r;
		r = '{kind: ROW_REG, op: OP_DATA, data: '0, last: 1'b0, typed: 1'b0,
			want: '0, reg_idx: idx, reg_val: val};
		stim_rows = {stim_rows, r};
	endtask

	task automatic build_table();
		// before any key schedule: plain pass-through, byte extremes
		add_passthru(8'h00, 1'b0);
		add_passthru(8'hFF, 1'b1);
		add_passthru(8'hA5, 1'b0);
		add_passthru(8'h5A, 1'b1);
		// default key, with junk on the ignored fields of the rekey
		add_item(OP_REKEY, 8'hFF, 1'b1);
		add_item(OP_DATA, 8'h00, 1'b0);
		add_item(OP_DATA, 8'hFF, 1'b1);
		add_item(OP_DATA, 8'h00, 1'b1);
		add_item(OP_DATA, 8'hFF, 1'b0);
		// write to the spare index must not disturb the key
		add_reg(CFG_IDX_SPARE, '1);
		add_item(OP_REKEY, 8'h00, 1'b0);
		add_item(OP_DATA, 8'h00, 1'b0);
		add_item(OP_DATA, 8'h00, 1'b0);
		// longest key, all ones
		add_reg(CFG_KEY_LOW, '1);
		add_reg(CFG_KEY_HIGH, '1);
		add_reg(CFG_KEY_LENGTH, 64'd16);
		add_item(OP_REKEY, 8'h00, 1'b0);
		add_item(OP_DATA, 8'hFF, 1'b1);
		add_item(OP_DATA, 8'h00, 1'b0);
		// zero length acts as one byte, all-zero key
		add_reg(CFG_KEY_LOW, '0);
		add_reg(CFG_KEY_HIGH, '0);
		add_reg(CFG_KEY_LENGTH, 64'd0);
		add_item(OP_REKEY, 8'hFF, 1'b1);
		add_item(OP_DATA, 8'h3C, 1'b0);
		// length 31 with junk upper bits saturates to the maximum
		add_reg(CFG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
		add_reg(CFG_KEY_HIGH, 64'hFEDC_BA98_7654_3210);
		add_reg(CFG_KEY_LENGTH, '1);
		add_item(OP_REKEY, 8'h00, 1'b0);
		add_item(OP_DATA, 8'h00, 1'b0);
		add_item(OP_DATA, 8'hFF, 1'b1);
		// shortest key
		add_reg(CFG_KEY_LENGTH, 64'd1);
		add_item(OP_REKEY, 8'h00, 1'b0);
		add_item(OP_DATA, 8'h81, 1'b1);
	endtask

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// gap before the next input transaction: bursts, with calm stretches
	function automatic int next_tx_gap();
		if (quiet)
			return 0;
		if (tx_calm > 0) begin
			tx_calm--;
			return 0;
		end
		case ($urandom_range(0, 11))
			0, 1, 2: return $urandom_range(1, 7);
			3: begin
				tx_calm = $urandom_range(10, 40);
				return 0;
			end
			default: return 0;
		endcase
	endfunction

	// enter at a falling edge; leave at the falling edge after acceptance
	// with valid still high, so a back-to-back transaction keeps it up
	task automatic send_item(input logic op, input byte_t data, input logic last,
			input bit typed, input cipher_out_t typed_res);
		int          gap;
		bit          produces;
		cipher_out_t res;
		gap = next_tx_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation = op;
		data_in   = data;
		last_byte = last;
		in_valid  = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		cipher_step(op, data, last, produces, res);
		if (produces)
			expected_bytes = {expected_bytes, (typed ? typed_res : res)};
		last_was_rekey = (op == OP_REKEY);
		@(negedge clk);
	endtask

	// drop valid and hold until the engine is known to be idle
	task automatic wait_idle();
		in_valid = 1'b0;
		while (expected_bytes.size() != 0)
			@(negedge clk);
		// a rekey leaves nothing to wait on, so sit out its schedule
		if (last_was_rekey) begin
			repeat (SETTLE) @(negedge clk);
			last_was_rekey = 1'b0;
		end else begin
			repeat (4) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_REG_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		apply_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
		@(negedge clk);
	endtask

	task automatic program_random_key();
		logic [KEY_REG_W-1:0] len_val;
		case ($urandom_range(0, 7))
			0: begin
				write_reg(CFG_KEY_LOW, '0);
				write_reg(CFG_KEY_HIGH, '0);
			end
			1: begin
				write_reg(CFG_KEY_LOW, '1);
				write_reg(CFG_KEY_HIGH, '1);
			end
			default: begin
				write_reg(CFG_KEY_LOW, {$urandom, $urandom});
				write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
			end
		endcase
		// junk in the upper bits must be dropped by the 5-bit register
		len_val = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: len_val[KEY_LEN_W-1:0] = 5'd0;
			1: len_val[KEY_LEN_W-1:0] = KEY_LEN_W'($urandom_range(17, 31));
			2: len_val[KEY_LEN_W-1:0] = 5'd1;
			3: len_val[KEY_LEN_W-1:0] = 5'd16;
			default: len_val[KEY_LEN_W-1:0] = KEY_LEN_W'($urandom_range(1, 16));
		endcase
		write_reg(CFG_KEY_LENGTH, len_val);
		if ($urandom_range(0, 5) == 0)
			write_reg(CFG_IDX_SPARE, {$urandom, $urandom});
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls, calm stretches, and one long hold-off
	// ------------------------------------------------------------------
	initial begin
		int rx_stall;
		int rx_calm;
		int hold_left;
		rx_stall  = 0;
		rx_calm   = 0;
		hold_left = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else if (quiet) begin
				out_ready = 1'b1;
			end else if (rx_stall > 0) begin
				rx_stall--;
				out_ready = 1'b0;
			end else if (rx_calm > 0) begin
				rx_calm--;
				out_ready = 1'b1;
			end else begin
				case ($urandom_range(0, 11))
					0, 1, 2: begin
						rx_stall = $urandom_range(1, 7) - 1;
						out_ready = 1'b0;
					end
					3: begin
						rx_calm = $urandom_range(10, 40);
						out_ready = 1'b1;
					end
					default: out_ready = 1'b1;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: compare each accepted byte with the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cipher_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected result: data_out %02h last_byte_out %0b",
					$time, data_out, last_byte_out);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				if (data_out !== want.data) begin
					$display("%0t: data_out mismatch: expected %02h, actual %02h",
						$time, want.data, data_out);
					errors++;
				end
				if (last_byte_out !== want.last) begin
					$display("%0t: last_byte_out mismatch: expected %0b, actual %0b",
						$time, want.last, last_byte_out);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int  rand_items;
		int  phase;
		int  burst;
		bit  do_rekey;
		stim_row_t r;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		operation = OP_DATA;
		data_in   = '0;
		last_byte = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_KEY_LOW;
		cfg_wdata = '0;

		// model comes out of reset with the default key and no schedule
		key_lo_m  = KEY_LOW_RST;
		key_hi_m  = KEY_HIGH_RST;
		key_len_m = KEY_LENGTH_RST;
		ks_i      = '0;
		ks_j      = '0;
		keyed_m   = 1'b0;
		foreach (sbox[n])
			sbox[n] = '0;

		build_table();

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// walk the directed table; registers only move while idle
		foreach (stim_rows[k]) begin
			r = stim_rows[k];
			if (r.kind == ROW_REG) begin
				if (k == 0 || stim_rows[k-1].kind != ROW_REG)
					wait_idle();
				write_reg(r.reg_idx, r.reg_val);
			end else begin
				send_item(r.op, r.data, r.last, r.typed, r.want);
			end
		end

		// random phases: new key, schedule, then a stream of data bytes.
		// Some phases skip the rekey so the old stream must keep running
		// regardless of the new register values; a few stray rekeys land
		// in the middle of a stream.
		rand_items = 0;
		phase = 0;
		while (rand_items < RANDOM_ITEMS) begin
			wait_idle();
			program_random_key();
			do_rekey = (phase < 2) || ($urandom_range(0, 5) != 0);
			if (do_rekey) begin
				send_item(OP_REKEY, byte_t'($urandom), 1'($urandom), 1'b0, '0);
				rand_items++;
			end
			burst = $urandom_range(8, 40);
			for (int b = 0; b < burst && rand_items < RANDOM_ITEMS; b++) begin
				if (rand_items >= RANDOM_ITEMS - QUIET_ITEMS)
					quiet = 1'b1;
				if (b != 0 && $urandom_range(0, 29) == 0)
					send_item(OP_REKEY, byte_t'($urandom), 1'($urandom), 1'b0, '0);
				else
					send_item(OP_DATA, byte_t'($urandom), 1'($urandom), 1'b0, '0);
				rand_items++;
				// once keyed and drained, starve the output while the
				// input keeps offering bytes so the engine backs up
				if (phase == 2 && b == 0) begin
					wait_idle();
					hold_requests++;
				end
			end
			phase++;
		end

		wait_idle();
		repeat (SETTLE) @(negedge clk);
		if (expected_bytes.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_bytes.size());
			errors++;
		end

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
